// ===== hdl/i2c_rac_pkg.sv =====
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps

package i2c_rac_pkg;

  // Request function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Position within the transaction sequence.
  localparam logic [2:0] STEP_ADDR_W = 3'd0;
  localparam logic [2:0] STEP_REG    = 3'd1;
  localparam logic [2:0] STEP_DATA   = 3'd2;
  localparam logic [2:0] STEP_ADDR_R = 3'd3;
  localparam logic [2:0] STEP_RECV   = 3'd4;
  localparam logic [2:0] STEP_FINAL  = 3'd5;

  // Ticks per quarter-bit phase after reset.
  localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd150;

  // Index of the bit slot that carries the acknowledge.
  localparam logic [3:0] ACK_SLOT = 4'd8;

  typedef enum logic [4:0] {
    SEG_IDLE  = 5'b00001,
    SEG_START = 5'b00010,
    SEG_SEND  = 5'b00100,
    SEG_RECV  = 5'b01000,
    SEG_STOP  = 5'b10000
  } seg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [7:0] rdata;
  } res_t;

endpackage

// ===== hdl/i2c_register_access_master.sv =====
// Top level of the I2C master that performs single-register writes and reads.
//
// Usage: every request on the in channel is either a tick, which carries the
// sampled SDA level and advances bit timing, or a start command for a write
// or a read of one register. A start command is ignored while a transaction
// is in progress, and a tick is ignored while idle. Each quarter of an SCL
// bit lasts ticks_per_phase ticks, set through cfg_we / cfg_wdata while no
// request is in flight; a value of zero acts as one.
// Every request produces exactly one result on the out channel: the SCL and
// SDA drive levels after that request, busy, a done pulse on the tick that
// completes the final stop, the acknowledge status and the last byte read.
// The result is registered: it shows right after the edge that accepts the request.
// Throughput is one request per cycle while the receiver keeps taking results,
// set by the single result register that follows the sequencer; the sequencer
// itself is updated in the same cycle as the request is taken.
// When the receiver stalls, the result register holds and in_ready drops
// only while that register is full and not being taken.
// Reset clears the sequencer to idle, both lines released high, status and
// read data zero, and ticks_per_phase back to 150. No result is pending.
`timescale 1ns / 1ps

module i2c_register_access_master
  import i2c_rac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  // Configuration register.
  logic [15:0] ticks_per_phase;

  // Sequencer state.
  seg_t        seg, seg_next;
  logic [1:0]  quarter, quarter_next;
  logic [3:0]  bit_cnt, bit_cnt_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [2:0]  byte_step, byte_step_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [6:0]  latched_addr, latched_addr_next;
  logic [7:0]  latched_reg, latched_reg_next;
  logic [7:0]  latched_data, latched_data_next;
  logic        is_read, is_read_next;
  logic        status_reg, status_reg_next;
  logic [7:0]  rx_byte, rx_byte_next;

  logic        accept;
  logic        busy;
  logic        done;
  logic [15:0] limit;
  logic [16:0] timer_inc;
  res_t        res_next;

  // A new request is taken whenever the result register is free or is being
  // emptied in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign busy     = (seg != SEG_IDLE);
  assign limit    = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
  assign timer_inc = {1'b0, phase_timer} + 17'd1;

  always_comb begin
    seg_next          = seg;
    quarter_next      = quarter;
    bit_cnt_next      = bit_cnt;
    shift_reg_next    = shift_reg;
    byte_step_next    = byte_step;
    phase_timer_next  = phase_timer;
    latched_addr_next = latched_addr;
    latched_reg_next  = latched_reg;
    latched_data_next = latched_data;
    is_read_next      = is_read;
    status_reg_next   = status_reg;
    rx_byte_next      = rx_byte;
    done              = 1'b0;

    if (in_req.func == FUNC_TICK) begin
      if (busy) begin
        if (timer_inc >= {1'b0, limit}) begin
          phase_timer_next = 16'd0;
          // End of the current quarter-bit phase.
          unique case (seg)
            SEG_START: begin
              if (!quarter[1]) begin
                quarter_next = quarter + 2'd1;
              end else begin
                shift_reg_next = {latched_addr, (byte_step == STEP_ADDR_R)};
                bit_cnt_next   = 4'd0;
                seg_next       = SEG_SEND;
                quarter_next   = 2'd0;
              end
            end
            SEG_SEND: begin
              // The acknowledge is sampled while SCL is high.
              if (quarter == 2'd1 && bit_cnt == ACK_SLOT) begin
                shift_reg_next = {7'd0, in_req.sda_in};
              end
              if (quarter != 2'd3) begin
                quarter_next = quarter + 2'd1;
              end else if (bit_cnt != ACK_SLOT) begin
                shift_reg_next = {shift_reg[6:0], 1'b0};
                bit_cnt_next   = bit_cnt + 4'd1;
                quarter_next   = 2'd0;
              end else if (shift_reg[0]) begin
                // Target did not acknowledge: abort through a stop.
                status_reg_next = 1'b1;
                byte_step_next  = STEP_FINAL;
                seg_next        = SEG_STOP;
                quarter_next    = 2'd0;
              end else begin
                priority if (byte_step == STEP_ADDR_W) begin
                  byte_step_next = STEP_REG;
                  shift_reg_next = latched_reg;
                  bit_cnt_next   = 4'd0;
                  quarter_next   = 2'd0;
                end else if (byte_step == STEP_REG) begin
                  byte_step_next = STEP_DATA;
                  quarter_next   = 2'd0;
                  if (is_read) begin
                    seg_next = SEG_STOP;
                  end else begin
                    shift_reg_next = latched_data;
                    bit_cnt_next   = 4'd0;
                  end
                end else if (byte_step == STEP_ADDR_R) begin
                  byte_step_next = STEP_RECV;
                  shift_reg_next = 8'd0;
                  bit_cnt_next   = 4'd0;
                  seg_next       = SEG_RECV;
                  quarter_next   = 2'd0;
                end else begin
                  byte_step_next = STEP_FINAL;
                  seg_next       = SEG_STOP;
                  quarter_next   = 2'd0;
                end
              end
            end
            SEG_RECV: begin
              if (quarter == 2'd1 && bit_cnt != ACK_SLOT) begin
                shift_reg_next = {shift_reg[6:0], in_req.sda_in};
              end
              if (quarter != 2'd3) begin
                quarter_next = quarter + 2'd1;
              end else if (bit_cnt != ACK_SLOT) begin
                bit_cnt_next = bit_cnt + 4'd1;
                quarter_next = 2'd0;
              end else begin
                rx_byte_next   = shift_reg;
                byte_step_next = STEP_FINAL;
                seg_next       = SEG_STOP;
                quarter_next   = 2'd0;
              end
            end
            SEG_STOP: begin
              if (!quarter[1]) begin
                quarter_next = quarter + 2'd1;
              end else if (is_read && byte_step == STEP_DATA) begin
                // A stop, then a fresh start for the read half of a register read.
                byte_step_next = STEP_ADDR_R;
                seg_next       = SEG_START;
                quarter_next   = 2'd0;
              end else begin
                seg_next       = SEG_IDLE;
                quarter_next   = 2'd0;
                bit_cnt_next   = 4'd0;
                byte_step_next = STEP_ADDR_W;
                done           = 1'b1;
              end
            end
            default: begin
              seg_next     = SEG_IDLE;
              quarter_next = 2'd0;
            end
          endcase
        end else begin
          phase_timer_next = timer_inc[15:0];
        end
      end
    end else if ((in_req.func == FUNC_WRITE || in_req.func == FUNC_READ) && !busy) begin
      latched_addr_next = in_req.dev_addr;
      latched_reg_next  = in_req.reg_addr;
      latched_data_next = in_req.wdata;
      is_read_next      = (in_req.func == FUNC_READ);
      status_reg_next   = 1'b0;
      byte_step_next    = STEP_ADDR_W;
      bit_cnt_next      = 4'd0;
      shift_reg_next    = 8'd0;
      phase_timer_next  = 16'd0;
      seg_next          = SEG_START;
      quarter_next      = 2'd0;
    end
  end

  // Line levels and status as they stand after this request.
  always_comb begin
    res_next.scl_level = 1'b1;
    res_next.sda_level = 1'b1;
    unique case (seg_next)
      SEG_START: begin
        res_next.scl_level = !quarter_next[1];
        res_next.sda_level = (quarter_next == 2'd0);
      end
      SEG_SEND: begin
        res_next.scl_level = (quarter_next == 2'd1 || quarter_next == 2'd2);
        res_next.sda_level = (bit_cnt_next != ACK_SLOT) ? shift_reg_next[7] : 1'b1;
      end
      SEG_RECV: begin
        res_next.scl_level = (quarter_next == 2'd1 || quarter_next == 2'd2);
      end
      SEG_STOP: begin
        res_next.scl_level = (quarter_next != 2'd0);
        res_next.sda_level = (quarter_next == 2'd2);
      end
      default: begin
        res_next.scl_level = 1'b1;
      end
    endcase
    res_next.busy_res = (seg_next != SEG_IDLE);
    res_next.done_res = done;
    res_next.status   = status_reg_next;
    res_next.rdata    = rx_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= TICKS_PER_PHASE_RESET;
    end else if (cfg_we) begin
      ticks_per_phase <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg          <= SEG_IDLE;
      quarter      <= 2'd0;
      bit_cnt      <= 4'd0;
      shift_reg    <= 8'd0;
      byte_step    <= STEP_ADDR_W;
      phase_timer  <= 16'd0;
      latched_addr <= 7'd0;
      latched_reg  <= 8'd0;
      latched_data <= 8'd0;
      is_read      <= 1'b0;
      status_reg   <= 1'b0;
      rx_byte      <= 8'd0;
    end else if (accept) begin
      seg          <= seg_next;
      quarter      <= quarter_next;
      bit_cnt      <= bit_cnt_next;
      shift_reg    <= shift_reg_next;
      byte_step    <= byte_step_next;
      phase_timer  <= phase_timer_next;
      latched_addr <= latched_addr_next;
      latched_reg  <= latched_reg_next;
      latched_data <= latched_data_next;
      is_read      <= is_read_next;
      status_reg   <= status_reg_next;
      rx_byte      <= rx_byte_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res_next;
    end
  end

  // A finished transaction is never reported as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> !out_res.busy_res)
    else $error("done reported while busy");

  // With no transaction in progress both lines are released.
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.busy_res |-> out_res.scl_level && out_res.sda_level)
    else $error("line driven low while idle");

  // The bit counter never passes the acknowledge slot.
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= ACK_SLOT)
    else $error("bit counter out of range");

  // A start command taken while idle opens with the first quarter of a start.
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    accept && seg == SEG_IDLE && (in_req.func == FUNC_WRITE || in_req.func == FUNC_READ)
    |=> seg == SEG_START && quarter == 2'd0 && out_res.busy_res)
    else $error("start command did not begin a start condition");

endmodule

// ===== verif/tb_i2c_register_access_master.sv =====
// Self-checking testbench for the single-register I2C access master.
`timescale 1ns / 1ps

module tb_i2c_register_access_master;
  import i2c_rac_pkg::*;

  // The request function code that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // A hard ceiling on the run, far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // Length of the one long receiver hold-off that backs the block up.
  localparam int unsigned LONG_HOLD = 400;

  // How the driver settles SDA on a tick that lands on an acknowledge sample.
  // With ACK_MOSTLY the target acknowledges almost always, so that most
  // transactions get through every byte; with ACK_NEVER it refuses at once.
  typedef enum logic [1:0] {
    ACK_AS_GIVEN,
    ACK_MOSTLY,
    ACK_NEVER
  } ack_mode_t;

  typedef struct packed {
    req_t      req;
    ack_mode_t mode;
  } queued_req_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_res;

  i2c_register_access_master u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Requests waiting to be offered, and the line states the block owes us.
  queued_req_t req_backlog[$];
  res_t        line_due[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // When set, neither side inserts random idle cycles.
  bit no_idle = 1'b0;

  // The stimulus process asks for the long hold-off by bumping hold_asked;
  // the receiver process counts the hold itself.
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  // Our own copy of the sequencer. It advances once per accepted request,
  // in the order the block takes them, so at any edge it describes exactly
  // the state the next accepted request will act on.
  seg_t        sq_seg = SEG_IDLE;
  logic [1:0]  sq_qtr = 2'd0;
  logic [3:0]  sq_bit = 4'd0;
  logic [7:0]  sq_shift = 8'd0;
  logic [2:0]  sq_step = STEP_ADDR_W;
  logic [15:0] sq_timer = 16'd0;
  logic [6:0]  sq_addr = 7'd0;
  logic [7:0]  sq_reg = 8'd0;
  logic [7:0]  sq_data = 8'd0;
  logic        sq_rd = 1'b0;
  logic        sq_nack = 1'b0;
  logic [7:0]  sq_rbyte = 8'd0;
  logic [15:0] sq_tpp = TICKS_PER_PHASE_RESET;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A programmed length of zero behaves as one tick per quarter.
  function automatic int unsigned quarter_len();
    return (sq_tpp == 16'd0) ? 1 : sq_tpp;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    sq_shift = b;
    sq_bit = 4'd0;
    sq_seg = SEG_SEND;
    sq_qtr = 2'd0;
  endfunction

  // Moves the sequencer past the end of one quarter-bit phase. SDA is
  // sampled at the end of the second quarter, while SCL is high. Returns
  // high when the closing stop condition has just completed.
  function automatic logic close_quarter(logic sda);
    logic finished;
    finished = 1'b0;
    case (sq_seg)
      SEG_START: begin
        if (sq_qtr < 2'd2) begin
          sq_qtr = sq_qtr + 2'd1;
        end else begin
          // The second start of a read carries the read bit.
          load_byte({sq_addr, sq_step == STEP_ADDR_R});
        end
      end
      SEG_SEND: begin
        if (sq_qtr == 2'd1 && sq_bit == ACK_SLOT) sq_shift = {7'd0, sda};
        if (sq_qtr < 2'd3) begin
          sq_qtr = sq_qtr + 2'd1;
        end else if (sq_bit < ACK_SLOT) begin
          sq_shift = sq_shift << 1;
          sq_bit = sq_bit + 4'd1;
          sq_qtr = 2'd0;
        end else if (sq_shift[0]) begin
          // The target refused the byte, so the transfer goes straight to stop.
          sq_nack = 1'b1;
          sq_step = STEP_FINAL;
          sq_seg = SEG_STOP;
          sq_qtr = 2'd0;
        end else begin
          case (sq_step)
            STEP_ADDR_W: begin
              sq_step = STEP_REG;
              load_byte(sq_reg);
            end
            STEP_REG: begin
              sq_step = STEP_DATA;
              if (sq_rd) begin
                sq_seg = SEG_STOP;
                sq_qtr = 2'd0;
              end else begin
                load_byte(sq_data);
              end
            end
            STEP_ADDR_R: begin
              sq_step = STEP_RECV;
              sq_shift = 8'd0;
              sq_bit = 4'd0;
              sq_seg = SEG_RECV;
              sq_qtr = 2'd0;
            end
            default: begin
              sq_step = STEP_FINAL;
              sq_seg = SEG_STOP;
              sq_qtr = 2'd0;
            end
          endcase
        end
      end
      SEG_RECV: begin
        if (sq_qtr == 2'd1 && sq_bit < ACK_SLOT) sq_shift = {sq_shift[6:0], sda};
        if (sq_qtr < 2'd3) begin
          sq_qtr = sq_qtr + 2'd1;
        end else if (sq_bit < ACK_SLOT) begin
          sq_bit = sq_bit + 4'd1;
          sq_qtr = 2'd0;
        end else begin
          // The master's own acknowledge slot is a release, so the byte is kept.
          sq_rbyte = sq_shift;
          sq_step = STEP_FINAL;
          sq_seg = SEG_STOP;
          sq_qtr = 2'd0;
        end
      end
      SEG_STOP: begin
        if (sq_qtr < 2'd2) begin
          sq_qtr = sq_qtr + 2'd1;
        end else if (sq_rd && sq_step == STEP_DATA) begin
          // A read stops after the register byte and restarts for the data.
          sq_step = STEP_ADDR_R;
          sq_seg = SEG_START;
          sq_qtr = 2'd0;
        end else begin
          sq_seg = SEG_IDLE;
          sq_qtr = 2'd0;
          sq_bit = 4'd0;
          sq_step = STEP_ADDR_W;
          finished = 1'b1;
        end
      end
      default: begin
        sq_seg = SEG_IDLE;
        sq_qtr = 2'd0;
      end
    endcase
    return finished;
  endfunction

  // Applies one request to the sequencer copy and returns the line state
  // that the block must report for it.
  function automatic res_t apply_request(req_t r);
    res_t  o;
    logic  finished;
    logic  active;
    finished = 1'b0;
    active = sq_seg != SEG_IDLE;
    if (r.func == FUNC_TICK) begin
      if (active) begin
        if (sq_timer + 1 >= quarter_len()) begin
          sq_timer = 16'd0;
          finished = close_quarter(r.sda_in);
        end else begin
          sq_timer = sq_timer + 16'd1;
        end
      end
    end else if ((r.func == FUNC_WRITE || r.func == FUNC_READ) && !active) begin
      sq_addr = r.dev_addr;
      sq_reg = r.reg_addr;
      sq_data = r.wdata;
      sq_rd = r.func == FUNC_READ;
      sq_nack = 1'b0;
      sq_step = STEP_ADDR_W;
      sq_bit = 4'd0;
      sq_shift = 8'd0;
      sq_timer = 16'd0;
      sq_seg = SEG_START;
      sq_qtr = 2'd0;
    end

    o = '0;
    o.scl_level = 1'b1;
    o.sda_level = 1'b1;
    case (sq_seg)
      SEG_START: begin
        o.scl_level = sq_qtr < 2'd2;
        o.sda_level = sq_qtr == 2'd0;
      end
      SEG_SEND: begin
        o.scl_level = sq_qtr == 2'd1 || sq_qtr == 2'd2;
        o.sda_level = (sq_bit < ACK_SLOT) ? sq_shift[7] : 1'b1;
      end
      SEG_RECV: begin
        o.scl_level = sq_qtr == 2'd1 || sq_qtr == 2'd2;
      end
      SEG_STOP: begin
        o.scl_level = sq_qtr != 2'd0;
        o.sda_level = sq_qtr == 2'd2;
      end
      default: ;
    endcase
    o.busy_res = sq_seg != SEG_IDLE;
    o.done_res = finished;
    o.status = sq_nack;
    o.rdata = sq_rbyte;
    return o;
  endfunction

  // Request side. When a request is taken, the expected line state is
  // computed at once; the next request is then picked with the sequencer
  // copy already up to date, which lets the driver decide how the target
  // answers an acknowledge slot before the tick is offered.
  always @(posedge clk) begin : req_driver
    queued_req_t pick;
    req_t        nxt_req;
    logic        nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_req = in_req;
      if (in_valid && in_ready) begin
        line_due.push_back(apply_request(in_req));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && req_backlog.size() != 0 &&
          (no_idle || $urandom_range(0, 99) >= 33)) begin
        pick = req_backlog.pop_front();
        nxt_req = pick.req;
        if (pick.mode != ACK_AS_GIVEN && pick.req.func == FUNC_TICK &&
            sq_seg == SEG_SEND && sq_qtr == 2'd1 && sq_bit == ACK_SLOT &&
            sq_timer + 1 >= quarter_len()) begin
          // Roughly one acknowledge in sixteen is refused in the mostly-ack
          // mode, so aborts turn up at every byte the master sends.
          nxt_req.sda_in = (pick.mode == ACK_NEVER) || ($urandom_range(0, 15) == 0);
        end
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_req <= nxt_req;
    end
  end

  // Result side ready. Apart from random idling, it honors one long
  // hold-off on request from the stimulus process.
  always @(posedge clk) begin : res_ready_ctrl
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  // Each accepted result is checked against the oldest expected line state.
  always @(posedge clk) begin : res_checker
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (line_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches = mismatches + 1;
      end else begin
        want = line_due.pop_front();
        if (out_res.scl_level !== want.scl_level) begin
          $error("scl_level: expected %0d, got %0d", want.scl_level, out_res.scl_level);
          mismatches = mismatches + 1;
        end
        if (out_res.sda_level !== want.sda_level) begin
          $error("sda_level: expected %0d, got %0d", want.sda_level, out_res.sda_level);
          mismatches = mismatches + 1;
        end
        if (out_res.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_res.busy_res);
          mismatches = mismatches + 1;
        end
        if (out_res.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_res.done_res);
          mismatches = mismatches + 1;
        end
        if (out_res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_res.status);
          mismatches = mismatches + 1;
        end
        if (out_res.rdata !== want.rdata) begin
          $error("rdata: expected 0x%02h, got 0x%02h", want.rdata, out_res.rdata);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("i2c_register_access_master verification failed");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] func, logic [6:0] dev, logic [7:0] reg_byte,
                           logic [7:0] data, logic sda, ack_mode_t mode);
    queued_req_t q;
    q.req.func = func;
    q.req.dev_addr = dev;
    q.req.reg_addr = reg_byte;
    q.req.wdata = data;
    q.req.sda_in = sda;
    q.mode = mode;
    req_backlog.push_back(q);
  endtask

  // A tick carries junk in the address and data fields; only SDA matters.
  task automatic queue_tick(ack_mode_t mode);
    queue_req(FUNC_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), mode);
  endtask

  // Waits until every request has been taken and answered.
  task automatic settle();
    while (req_backlog.size() != 0 || in_valid || line_due.size() != 0) @(posedge clk);
  endtask

  // Feeds ticks until the transaction in flight has completed its stop.
  task automatic finish_transfer(ack_mode_t mode);
    settle();
    while (sq_seg != SEG_IDLE) begin
      repeat (64) queue_tick(mode);
      settle();
    end
  endtask

  // Rewrites the phase length once every request has been taken and
  // answered. A transfer may still be running; it carries on at the new
  // length from the next tick.
  task automatic set_quarter_len(logic [15:0] ticks);
    settle();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    sq_tpp = ticks;
  endtask

  // Random transactions: each starts with a write or read request followed
  // by a run of ticks whose length is on the order of a full transfer at
  // the current phase length, cut short where the budget runs out. About one
  // tenth of the items are noise: unused function codes, requests that
  // land while busy, and ticks whose SDA is left to chance at the
  // acknowledge slot.
  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned span;
    int unsigned roll;
    logic [1:0]  op;
    sent = 0;
    while (sent < budget) begin
      op = ($urandom_range(0, 1) != 0) ? FUNC_WRITE : FUNC_READ;
      queue_req(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ACK_MOSTLY);
      span = $urandom_range(10, 210 * quarter_len());
      if (span > budget - sent - 1) span = budget - sent - 1;
      sent = sent + span + 1;
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          op = (roll == 0) ? FUNC_UNUSED : ((roll == 1) ? FUNC_WRITE : FUNC_READ);
          queue_req(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ACK_AS_GIVEN);
        end else if (roll < 10) begin
          queue_tick(ACK_AS_GIVEN);
        end else begin
          queue_tick(ACK_MOSTLY);
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // At the reset phase length: ticks and the unused code while idle, a
    // write with extreme fields, then a read and the unused code while the
    // write is still running, both of which must be ignored. Enough ticks
    // follow for the first quarter of the start to close at 150 ticks.
    queue_req(FUNC_TICK, 7'h7F, 8'hFF, 8'hFF, 1'b0, ACK_AS_GIVEN);
    queue_req(FUNC_TICK, 7'h00, 8'h00, 8'h00, 1'b1, ACK_AS_GIVEN);
    queue_req(FUNC_UNUSED, 7'h7F, 8'hFF, 8'hFF, 1'b1, ACK_AS_GIVEN);
    queue_req(FUNC_WRITE, 7'h7F, 8'hFF, 8'h00, 1'b0, ACK_AS_GIVEN);
    queue_req(FUNC_READ, 7'h00, 8'h00, 8'hFF, 1'b0, ACK_AS_GIVEN);
    queue_req(FUNC_UNUSED, 7'h00, 8'h00, 8'h00, 1'b0, ACK_AS_GIVEN);
    repeat (152) queue_tick(ACK_MOSTLY);
    settle();

    // A programmed length of zero must act as one tick per quarter. The
    // change lands in the middle of the write, which then runs to its stop.
    set_quarter_len(16'd0);
    finish_transfer(ACK_MOSTLY);

    // A read that the target refuses at once, so that the status flags it
    // and the last read byte is kept.
    queue_req(FUNC_READ, 7'h55, 8'hA5, 8'h3C, 1'b0, ACK_AS_GIVEN);
    finish_transfer(ACK_NEVER);

    // The receiver stops taking results for a long stretch while a full
    // backlog is offered, so the result register fills and input stalls.
    set_quarter_len(16'd1);
    random_traffic(200);
    hold_asked = hold_asked + 1;
    finish_transfer(ACK_MOSTLY);

    // From here on neither side idles.
    no_idle = 1'b1;
    set_quarter_len(16'd2);
    random_traffic(100);
    finish_transfer(ACK_MOSTLY);

    // Largest phase length: the phase timer counts through a run of ticks
    // without closing the first quarter. The transfer is left unfinished.
    set_quarter_len(16'hFFFF);
    queue_req(FUNC_READ, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0, ACK_AS_GIVEN);
    repeat (60) queue_tick(ACK_MOSTLY);
    settle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("i2c_register_access_master verification clean");
    end else begin
      $display("i2c_register_access_master verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/i2c_rac_pkg.sv
hdl/i2c_register_access_master.sv
verif/tb_i2c_register_access_master.sv
